>>> hdl/qmm_pkg.sv
package qmm_pkg;

    localparam int SPEED_BITS = 12;
    localparam int THR_W      = SPEED_BITS + 1;
    localparam int CORR_W     = 12;
    localparam int TIME_W     = 16;
    localparam int CFG_DATA_W = (SPEED_BITS > TIME_W) ? SPEED_BITS : TIME_W;
    localparam int CFG_IDX_W  = 3;
    // Wide enough for the clamped throttle plus three corrections of either sign.
    localparam int SUM_W      = ((SPEED_BITS > CORR_W) ? SPEED_BITS : CORR_W) + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD  = 3'd4;

    localparam logic [SPEED_BITS-1:0] RST_SPEED_MAX     = SPEED_BITS'(1000);
    localparam logic [SPEED_BITS-1:0] RST_SPEED_MIN     = '0;
    localparam logic [SPEED_BITS-1:0] RST_PROTECT_SPEED = SPEED_BITS'(50);
    localparam logic [TIME_W-1:0]     RST_PULSE_BASE    = 16'd1000;
    localparam logic [TIME_W-1:0]     RST_PULSE_PERIOD  = 16'd20000;

    typedef struct packed {
        logic [SPEED_BITS-1:0] speed_max;
        logic [SPEED_BITS-1:0] speed_min;
        logic [SPEED_BITS-1:0] protect_speed;
        logic [TIME_W-1:0]     pulse_base;
        logic [TIME_W-1:0]     pulse_period;
    } t_cfg;

    // Limit to the maximum first, then raise to the minimum, so the minimum wins.
    function automatic logic [SPEED_BITS-1:0] clamp_speed(
        input logic signed [SUM_W-1:0] v,
        input logic [SPEED_BITS-1:0]   smax,
        input logic [SPEED_BITS-1:0]   smin
    );
        logic signed [SUM_W-1:0] vmax;
        logic signed [SUM_W-1:0] vmin;
        logic signed [SUM_W-1:0] r;
        vmax = $signed({{(SUM_W-SPEED_BITS){1'b0}}, smax});
        vmin = $signed({{(SUM_W-SPEED_BITS){1'b0}}, smin});
        r = v;
        if (r > vmax) begin
            r = vmax;
        end
        if (r < vmin) begin
            r = vmin;
        end
        return r[SPEED_BITS-1:0];
    endfunction

endpackage

>>> hdl/qmm_chan.sv
module qmm_chan (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  qmm_pkg::t_cfg                       i_cfg,
    input  logic                                i_stop,
    input  logic signed [qmm_pkg::SUM_W-1:0]    i_sum,
    output logic [qmm_pkg::SPEED_BITS-1:0]      o_speed,
    output logic [qmm_pkg::TIME_W-1:0]          o_high_time,
    output logic [qmm_pkg::TIME_W-1:0]          o_low_time
);
    import qmm_pkg::*;

    logic [SPEED_BITS-1:0] r_spd3, r_spd4, r_spd5;
    logic [TIME_W-1:0]     r_hi4, r_hi5, r_lo5;
    logic [SPEED_BITS-1:0] n_spd3;
    logic [TIME_W:0]       n_hi_sum;
    logic [TIME_W-1:0]     n_hi4, n_lo5;

    always_comb begin
        n_spd3   = i_stop ? '0 : clamp_speed(i_sum, i_cfg.speed_max, i_cfg.speed_min);
        n_hi_sum = {1'b0, i_cfg.pulse_base} + (TIME_W+1)'(r_spd3);
        n_hi4    = n_hi_sum[TIME_W] ? '1 : n_hi_sum[TIME_W-1:0];
        n_lo5    = (i_cfg.pulse_period > r_hi4) ? (i_cfg.pulse_period - r_hi4) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spd3 <= n_spd3;
            r_spd4 <= r_spd3;
            r_hi4  <= n_hi4;
            r_spd5 <= r_spd4;
            r_hi5  <= r_hi4;
            r_lo5  <= n_lo5;
        end
    end

    assign o_speed     = r_spd5;
    assign o_high_time = r_hi5;
    assign o_low_time  = r_lo5;

endmodule

>>> hdl/quad_motor_mixer_pwm.sv
// An accepted command beat passes through five register stages (throttle clamp,
// mix, speed clamp, high time, low time) to its result on o_valid; the stages
// advance together, taking one beat per cycle, whenever the output is free.
// Reset clears all stage valid bits and loads the register defaults; the
// datapath registers are not reset.
module quad_motor_mixer_pwm (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [qmm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [qmm_pkg::THR_W-1:0]       i_throttle,
    input  logic                                   i_lock,
    input  logic signed [qmm_pkg::CORR_W-1:0]      i_roll_corr,
    input  logic signed [qmm_pkg::CORR_W-1:0]      i_pitch_corr,
    input  logic signed [qmm_pkg::CORR_W-1:0]      i_yaw_corr,
    input  logic signed [qmm_pkg::CORR_W-1:0]      i_roll_rate_corr,
    input  logic signed [qmm_pkg::CORR_W-1:0]      i_pitch_rate_corr,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [qmm_pkg::SPEED_BITS-1:0]         o_motor0_speed,
    output logic [qmm_pkg::SPEED_BITS-1:0]         o_motor1_speed,
    output logic [qmm_pkg::SPEED_BITS-1:0]         o_motor2_speed,
    output logic [qmm_pkg::SPEED_BITS-1:0]         o_motor3_speed,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor0_high_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor1_high_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor2_high_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor3_high_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor0_low_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor1_low_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor2_low_time,
    output logic [qmm_pkg::TIME_W-1:0]             o_motor3_low_time
);
    import qmm_pkg::*;

    localparam int NSTAGE = 5;

    function automatic logic signed [SUM_W-1:0] sx_corr(input logic signed [CORR_W-1:0] c);
        return $signed({{(SUM_W-CORR_W){c[CORR_W-1]}}, c});
    endfunction

    t_cfg r_cfg;
    logic [NSTAGE-1:0] r_vld;
    logic              en;

    // Stage 1: clamped throttle and registered corrections.
    logic [SPEED_BITS-1:0]    r_thr1;
    logic                     r_lock1;
    logic signed [CORR_W-1:0] r_rc1, r_pc1, r_yc1, r_rr1, r_pr1;
    logic [SPEED_BITS-1:0]    n_thr1;

    // Stage 2: stop decision and the four mixed sums.
    logic                    r_stop2;
    logic signed [SUM_W-1:0] r_sum2 [4];
    logic                    n_stop2;
    logic signed [SUM_W-1:0] n_sum2 [4];
    logic signed [SUM_W-1:0] thr_x;

    logic [SPEED_BITS-1:0] spd  [4];
    logic [TIME_W-1:0]     hi_t [4];
    logic [TIME_W-1:0]     lo_t [4];

    // The whole pipe moves unless a finished beat is held at the output.
    assign en      = !r_vld[NSTAGE-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_max     <= RST_SPEED_MAX;
            r_cfg.speed_min     <= RST_SPEED_MIN;
            r_cfg.protect_speed <= RST_PROTECT_SPEED;
            r_cfg.pulse_base    <= RST_PULSE_BASE;
            r_cfg.pulse_period  <= RST_PULSE_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_MAX:     r_cfg.speed_max     <= i_cfg_data[SPEED_BITS-1:0];
                CFG_SPEED_MIN:     r_cfg.speed_min     <= i_cfg_data[SPEED_BITS-1:0];
                CFG_PROTECT_SPEED: r_cfg.protect_speed <= i_cfg_data[SPEED_BITS-1:0];
                CFG_PULSE_BASE:    r_cfg.pulse_base    <= i_cfg_data[TIME_W-1:0];
                CFG_PULSE_PERIOD:  r_cfg.pulse_period  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    always_comb begin
        n_thr1 = clamp_speed($signed({{(SUM_W-THR_W){i_throttle[THR_W-1]}}, i_throttle}),
                             r_cfg.speed_max, r_cfg.speed_min);
        thr_x     = $signed({{(SUM_W-SPEED_BITS){1'b0}}, r_thr1});
        n_stop2   = r_lock1 || (r_thr1 < r_cfg.protect_speed);
        n_sum2[0] = thr_x - sx_corr(r_rc1) + sx_corr(r_yc1) - sx_corr(r_rr1);
        n_sum2[1] = thr_x - sx_corr(r_pc1) - sx_corr(r_yc1) + sx_corr(r_pr1);
        n_sum2[2] = thr_x + sx_corr(r_rc1) + sx_corr(r_yc1) + sx_corr(r_rr1);
        n_sum2[3] = thr_x + sx_corr(r_pc1) - sx_corr(r_yc1) - sx_corr(r_pr1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_thr1  <= n_thr1;
            r_lock1 <= i_lock;
            r_rc1   <= i_roll_corr;
            r_pc1   <= i_pitch_corr;
            r_yc1   <= i_yaw_corr;
            r_rr1   <= i_roll_rate_corr;
            r_pr1   <= i_pitch_rate_corr;
            r_stop2 <= n_stop2;
            for (int k = 0; k < 4; k++) begin
                r_sum2[k] <= n_sum2[k];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_motor
        qmm_chan u_chan (
            .i_clk       (i_clk),
            .i_en        (en),
            .i_cfg       (r_cfg),
            .i_stop      (r_stop2),
            .i_sum       (r_sum2[g]),
            .o_speed     (spd[g]),
            .o_high_time (hi_t[g]),
            .o_low_time  (lo_t[g])
        );
    end

    assign o_motor0_speed     = spd[0];
    assign o_motor1_speed     = spd[1];
    assign o_motor2_speed     = spd[2];
    assign o_motor3_speed     = spd[3];
    assign o_motor0_high_time = hi_t[0];
    assign o_motor1_high_time = hi_t[1];
    assign o_motor2_high_time = hi_t[2];
    assign o_motor3_high_time = hi_t[3];
    assign o_motor0_low_time  = lo_t[0];
    assign o_motor1_low_time  = lo_t[1];
    assign o_motor2_low_time  = lo_t[2];
    assign o_motor3_low_time  = lo_t[3];

    // The input side is held back only by a beat waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output beat");

    // The high time never falls below the configured base.
    a_high_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_motor0_high_time >= r_cfg.pulse_base))
        else $error("motor 0 high time below pulse base");

    // High and low time fill the period unless the high time alone exceeds it.
    a_period_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((({1'b0, o_motor2_high_time} + {1'b0, o_motor2_low_time})
                      == {1'b0, r_cfg.pulse_period})
                     || (o_motor2_low_time == '0
                         && o_motor2_high_time >= r_cfg.pulse_period)))
        else $error("motor 2 high and low time do not match the period");

    // With a sane range no motor runs above the maximum speed.
    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cfg.speed_min <= r_cfg.speed_max))
        |-> (o_motor1_speed <= r_cfg.speed_max))
        else $error("motor 1 speed above maximum");

endmodule

>>> sim/quad_motor_mixer_pwm_tb.sv
module quad_motor_mixer_pwm_tb;
    import qmm_pkg::*;

    typedef struct packed {
        logic [THR_W-1:0]  throttle;
        logic              lock;
        logic [CORR_W-1:0] roll_corr;
        logic [CORR_W-1:0] pitch_corr;
        logic [CORR_W-1:0] yaw_corr;
        logic [CORR_W-1:0] roll_rate_corr;
        logic [CORR_W-1:0] pitch_rate_corr;
    } flight_cmd_t;

    typedef struct packed {
        logic [3:0][SPEED_BITS-1:0] speed;
        logic [3:0][TIME_W-1:0]     high_time;
        logic [3:0][TIME_W-1:0]     low_time;
    } motor_out_t;

    localparam int RX_HOLD_CYCLES = 60;
    localparam int PIPE_LATENCY   = 5;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [THR_W-1:0]       i_throttle = '0;
    logic                          i_lock = 1'b0;
    logic signed [CORR_W-1:0]      i_roll_corr = '0;
    logic signed [CORR_W-1:0]      i_pitch_corr = '0;
    logic signed [CORR_W-1:0]      i_yaw_corr = '0;
    logic signed [CORR_W-1:0]      i_roll_rate_corr = '0;
    logic signed [CORR_W-1:0]      i_pitch_rate_corr = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [SPEED_BITS-1:0]         o_motor0_speed;
    logic [SPEED_BITS-1:0]         o_motor1_speed;
    logic [SPEED_BITS-1:0]         o_motor2_speed;
    logic [SPEED_BITS-1:0]         o_motor3_speed;
    logic [TIME_W-1:0]             o_motor0_high_time;
    logic [TIME_W-1:0]             o_motor1_high_time;
    logic [TIME_W-1:0]             o_motor2_high_time;
    logic [TIME_W-1:0]             o_motor3_high_time;
    logic [TIME_W-1:0]             o_motor0_low_time;
    logic [TIME_W-1:0]             o_motor1_low_time;
    logic [TIME_W-1:0]             o_motor2_low_time;
    logic [TIME_W-1:0]             o_motor3_low_time;

    quad_motor_mixer_pwm uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_throttle         (i_throttle),
        .i_lock             (i_lock),
        .i_roll_corr        (i_roll_corr),
        .i_pitch_corr       (i_pitch_corr),
        .i_yaw_corr         (i_yaw_corr),
        .i_roll_rate_corr   (i_roll_rate_corr),
        .i_pitch_rate_corr  (i_pitch_rate_corr),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_motor0_speed     (o_motor0_speed),
        .o_motor1_speed     (o_motor1_speed),
        .o_motor2_speed     (o_motor2_speed),
        .o_motor3_speed     (o_motor3_speed),
        .o_motor0_high_time (o_motor0_high_time),
        .o_motor1_high_time (o_motor1_high_time),
        .o_motor2_high_time (o_motor2_high_time),
        .o_motor3_high_time (o_motor3_high_time),
        .o_motor0_low_time  (o_motor0_low_time),
        .o_motor1_low_time  (o_motor1_low_time),
        .o_motor2_low_time  (o_motor2_low_time),
        .o_motor3_low_time  (o_motor3_low_time)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the block's registers, updated from the observed write port.
    logic [SPEED_BITS-1:0] cfg_speed_max     = RST_SPEED_MAX;
    logic [SPEED_BITS-1:0] cfg_speed_min     = RST_SPEED_MIN;
    logic [SPEED_BITS-1:0] cfg_protect_speed = RST_PROTECT_SPEED;
    logic [TIME_W-1:0]     cfg_pulse_base    = RST_PULSE_BASE;
    logic [TIME_W-1:0]     cfg_pulse_period  = RST_PULSE_PERIOD;

    flight_cmd_t pending_cmds[$];
    motor_out_t  expected_motors[$];
    int          mismatches = 0;
    bit          cmd_taken = 1'b0;
    bit          quiet = 1'b0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;

    function automatic int clamp_to_range(input int v);
        if (v > int'(cfg_speed_max)) begin
            v = int'(cfg_speed_max);
        end
        if (v < int'(cfg_speed_min)) begin
            v = int'(cfg_speed_min);
        end
        return v;
    endfunction

    function automatic motor_out_t mix_command(input flight_cmd_t c);
        motor_out_t r;
        int thr;
        int rc;
        int pc;
        int yc;
        int rr;
        int pr;
        int spd [4];
        int hi;
        thr = clamp_to_range(int'($signed(c.throttle)));
        rc  = int'($signed(c.roll_corr));
        pc  = int'($signed(c.pitch_corr));
        yc  = int'($signed(c.yaw_corr));
        rr  = int'($signed(c.roll_rate_corr));
        pr  = int'($signed(c.pitch_rate_corr));
        if (c.lock || thr < int'(cfg_protect_speed)) begin
            for (int k = 0; k < 4; k++) spd[k] = 0;
        end else begin
            spd[0] = clamp_to_range(thr - rc + yc - rr);
            spd[1] = clamp_to_range(thr - pc - yc + pr);
            spd[2] = clamp_to_range(thr + rc + yc + rr);
            spd[3] = clamp_to_range(thr + pc - yc - pr);
        end
        for (int k = 0; k < 4; k++) begin
            hi = int'(cfg_pulse_base) + spd[k];
            if (hi > 65535) begin
                hi = 65535;
            end
            r.speed[k]     = SPEED_BITS'(spd[k]);
            r.high_time[k] = TIME_W'(hi);
            r.low_time[k]  = (int'(cfg_pulse_period) > hi) ?
                             TIME_W'(int'(cfg_pulse_period) - hi) : '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int k, input int want,
                                   input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch motor%0d %s: expected %0d, got %0d", k, what, want, got);
        end
    endtask

    // Driver: presents queued commands, holds a stalled beat, idles in bursts.
    always @(negedge i_clk) begin : cmd_driver
        flight_cmd_t c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !cmd_taken) begin
            // Beat not taken yet: keep it unchanged.
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            i_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            i_valid           <= 1'b1;
            i_throttle        <= c.throttle;
            i_lock            <= c.lock;
            i_roll_corr       <= c.roll_corr;
            i_pitch_corr      <= c.pitch_corr;
            i_yaw_corr        <= c.yaw_corr;
            i_roll_rate_corr  <= c.roll_rate_corr;
            i_pitch_rate_corr <= c.pitch_rate_corr;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver back-pressure: short random bursts plus requested long hold-offs.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        flight_cmd_t seen;
        motor_out_t  want;
        motor_out_t  got;
        cmd_taken = i_valid && !o_stall;
        if (!i_rst_n) begin
            cfg_speed_max     <= RST_SPEED_MAX;
            cfg_speed_min     <= RST_SPEED_MIN;
            cfg_protect_speed <= RST_PROTECT_SPEED;
            cfg_pulse_base    <= RST_PULSE_BASE;
            cfg_pulse_period  <= RST_PULSE_PERIOD;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPEED_MAX:     cfg_speed_max     <= i_cfg_data[SPEED_BITS-1:0];
                    CFG_SPEED_MIN:     cfg_speed_min     <= i_cfg_data[SPEED_BITS-1:0];
                    CFG_PROTECT_SPEED: cfg_protect_speed <= i_cfg_data[SPEED_BITS-1:0];
                    CFG_PULSE_BASE:    cfg_pulse_base    <= i_cfg_data[TIME_W-1:0];
                    CFG_PULSE_PERIOD:  cfg_pulse_period  <= i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_taken) begin
                seen.throttle        = i_throttle;
                seen.lock            = i_lock;
                seen.roll_corr       = i_roll_corr;
                seen.pitch_corr      = i_pitch_corr;
                seen.yaw_corr        = i_yaw_corr;
                seen.roll_rate_corr  = i_roll_rate_corr;
                seen.pitch_rate_corr = i_pitch_rate_corr;
                expected_motors.push_back(mix_command(seen));
            end
            if (o_valid && !i_stall) begin
                got.speed     = {o_motor3_speed, o_motor2_speed,
                                 o_motor1_speed, o_motor0_speed};
                got.high_time = {o_motor3_high_time, o_motor2_high_time,
                                 o_motor1_high_time, o_motor0_high_time};
                got.low_time  = {o_motor3_low_time, o_motor2_low_time,
                                 o_motor1_low_time, o_motor0_low_time};
                if (expected_motors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result beat with no command outstanding");
                    end
                end else begin
                    want = expected_motors.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got.speed[k] !== want.speed[k])
                            report_mismatch("speed", k, int'(want.speed[k]),
                                            int'(got.speed[k]));
                        if (got.high_time[k] !== want.high_time[k])
                            report_mismatch("high_time", k, int'(want.high_time[k]),
                                            int'(got.high_time[k]));
                        if (got.low_time[k] !== want.low_time[k])
                            report_mismatch("low_time", k, int'(want.low_time[k]),
                                            int'(got.low_time[k]));
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    // Speed registers only keep the low bits; fill the rest with noise.
    function automatic logic [CFG_DATA_W-1:0] with_spare_bits(input int v);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[SPEED_BITS-1:0] = SPEED_BITS'(v);
        return d;
    endfunction

    task automatic set_cfg(input int smax, input int smin, input int prot,
                           input int base, input int period);
        write_reg(CFG_SPEED_MAX, with_spare_bits(smax));
        write_reg(CFG_SPEED_MIN, with_spare_bits(smin));
        write_reg(CFG_PROTECT_SPEED, with_spare_bits(prot));
        write_reg(CFG_PULSE_BASE, CFG_DATA_W'(base));
        write_reg(CFG_PULSE_PERIOD, CFG_DATA_W'(period));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_cmd(input int thr, input int lk, input int rc, input int pc,
                           input int yc, input int rr, input int pr);
        flight_cmd_t c;
        c.throttle        = THR_W'(thr);
        c.lock            = lk[0];
        c.roll_corr       = CORR_W'(rc);
        c.pitch_corr      = CORR_W'(pc);
        c.yaw_corr        = CORR_W'(yc);
        c.roll_rate_corr  = CORR_W'(rr);
        c.pitch_rate_corr = CORR_W'(pr);
        pending_cmds.push_back(c);
    endtask

    function automatic int small_corr();
        return int'($urandom_range(0, 800)) - 400;
    endfunction

    task automatic add_random_cmd(input int top);
        int lk;
        lk = ($urandom_range(0, 7) == 0) ? 1 : 0;
        if ($urandom_range(0, 3) == 0) begin
            add_cmd($urandom, lk, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            add_cmd(int'($urandom_range(0, top + 200)) - 100, lk, small_corr(),
                    small_corr(), small_corr(), small_corr(), small_corr());
        end
    endtask

    // Waits at rising edges, where a beat still on offer shows up as i_valid.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || i_valid || expected_motors.size() != 0);
    endtask

    task automatic random_phase(input int n_cmds, input bit long_hold);
        int mx;
        int mn;
        int pr;
        int bs;
        int pd;
        mx = ($urandom_range(0, 7) == 0) ? 4095 * int'($urandom_range(0, 1))
                                         : int'($urandom_range(200, 4095));
        mn = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095))
                                         : int'($urandom_range(0, mx / 4));
        pr = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095))
                                         : int'($urandom_range(0, mx / 2));
        bs = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(500, 2000));
        pd = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(3000, 25000));
        set_cfg(mx, mn, pr, bs, pd);
        for (int i = 0; i < n_cmds; i++) add_random_cmd(mx);
        // The long receiver hold-off lets the pipeline fill and stall its input.
        if (long_hold) hold_requests++;
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Writes to indexes past the last register must leave the defaults alone.
        for (int i = int'(CFG_PULSE_PERIOD) + 1; i < (1 << CFG_IDX_W); i++) begin
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;

        // Defaults: protect threshold, lock, throttle extremes, each correction.
        add_cmd(0, 0, 0, 0, 0, 0, 0);
        add_cmd(49, 0, 0, 0, 0, 0, 0);
        add_cmd(50, 0, 0, 0, 0, 0, 0);
        add_cmd(-4096, 0, 0, 0, 0, 0, 0);
        add_cmd(4095, 0, 0, 0, 0, 0, 0);
        add_cmd(500, 1, 100, 100, 100, 100, 100);
        add_cmd(500, 0, 2047, 0, 0, 0, 0);
        add_cmd(500, 0, 0, -2048, 0, 0, 0);
        add_cmd(500, 0, 0, 0, 2047, 0, 0);
        add_cmd(500, 0, 0, 0, -2048, 0, 0);
        add_cmd(500, 0, 0, 0, 0, 300, -300);
        add_cmd(4095, 0, -2048, -2048, -2048, -2048, -2048);
        add_cmd(4095, 0, 2047, 2047, 2047, 2047, 2047);
        wait_drained();

        // Full speed range, high time saturating and low time at zero.
        set_cfg(4095, 0, 0, 65535, 0);
        add_cmd(4095, 0, 0, 0, 0, 0, 0);
        add_cmd(-4096, 0, 2047, 0, 0, 0, 0);
        add_cmd(4095, 0, 2047, -2048, 2047, 2047, -2048);
        wait_drained();

        // High time just past the period, and the stopped case below it.
        set_cfg(4095, 0, 4095, 60000, 62000);
        add_cmd(4095, 0, 0, 0, 0, 0, 0);
        add_cmd(4094, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // Minimum above maximum: the minimum wins in every clamp.
        set_cfg(100, 3000, 0, 1000, 20000);
        add_cmd(0, 0, 0, 0, 0, 0, 0);
        add_cmd(2000, 0, 1500, -1500, 700, -700, 300);
        wait_drained();

        set_cfg(0, 0, 0, 0, 0);
        add_cmd(1000, 0, 5, -5, 5, -5, 5);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p == 7) quiet = 1'b1;
            random_phase(54, p == 2 || p == 5);
        end

        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (mismatches == 0 && expected_motors.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
